[rtl/core/lbmc_pkg.sv]
// Package for the LED brightness and mode controller: types, constants, duty tables.
`default_nettype none

package lbmc_pkg;

    // Field widths
    localparam int ARG_W   = 16;
    localparam int CODE_W  = 4;
    localparam int LEVEL_W = 3;
    localparam int DUTY_W  = 8;
    localparam int MODE_W  = 2;

    // Brightness range and hold repeat period
    localparam logic [LEVEL_W-1:0] TOP_LEVEL   = 3'd6;
    localparam int                 HOLD_PERIOD = 24;

    // Last valid duty table index
    localparam logic [LEVEL_W-1:0] TAB_LAST = 3'd6;

    // Divisibility test by HOLD_PERIOD through a scaled reciprocal.
    // With m = ceil(2^K / P) and K = ARG_W + 8 (P < 256),
    // arg % P == 0 exactly when the low K bits of arg * m are below m.
    localparam int HOLD_SHIFT = ARG_W + 8;
    localparam int RECIP_W    = HOLD_SHIFT + 1;
    localparam int PROD_W     = ARG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] HOLD_RECIP =
        RECIP_W'(((64'd1 << HOLD_SHIFT) + HOLD_PERIOD - 1) / HOLD_PERIOD);

    localparam logic [DUTY_W-1:0] SMALL_DUTY_TAB [7] = '{
        8'd3, 8'd18, 8'd110, 8'd255, 8'd255, 8'd255, 8'd0
    };
    localparam logic [DUTY_W-1:0] LARGE_DUTY_TAB [7] = '{
        8'd0, 8'd0, 8'd0, 8'd9, 8'd58, 8'd138, 8'd255
    };

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF    = 2'd0,
        MODE_STEADY = 2'd1,
        MODE_LOCK   = 2'd2
    } t_mode;

    typedef enum logic [CODE_W-1:0] {
        EV_PRESS       = 4'd0,
        EV_HOLD        = 4'd1,
        EV_RELEASE     = 4'd2,
        EV_CLICK1      = 4'd3,
        EV_CLICK2      = 4'd4,
        EV_CLICK4      = 4'd5,
        EV_HOT         = 4'd6,
        EV_COOL        = 4'd7,
        EV_TICK        = 4'd8,
        EV_LOW_VOLTAGE = 4'd9
    } t_event;

    typedef struct packed {
        logic [CODE_W-1:0] event_code;
        logic [ARG_W-1:0]  event_arg;
    } t_in_word;

    typedef struct packed {
        logic               handled;
        logic [MODE_W-1:0]  mode_now;
        logic [LEVEL_W-1:0] level_now;
        logic [DUTY_W-1:0]  duty_small_channel;
        logic [DUTY_W-1:0]  duty_large_channel;
        logic               standby_request;
    } t_out_word;

    typedef struct packed {
        t_mode              mode;
        logic [LEVEL_W-1:0] cur_level;
        logic [LEVEL_W-1:0] mem_level;
        logic [LEVEL_W-1:0] goal_level;
        logic [DUTY_W-1:0]  duty_small;
        logic [DUTY_W-1:0]  duty_large;
    } t_state;

    localparam t_state STATE_RESET = '{
        mode:       MODE_OFF,
        cur_level:  3'd0,
        mem_level:  3'd1,
        goal_level: 3'd0,
        duty_small: 8'd3,
        duty_large: 8'd0
    };

    localparam logic [ARG_W-1:0] STANDBY_DELAY_RESET = 16'd62;

    function automatic logic [LEVEL_W-1:0] tab_ix(input logic [LEVEL_W-1:0] lv);
        return (lv > TAB_LAST) ? TAB_LAST : lv;
    endfunction

    function automatic logic [DUTY_W-1:0] small_duty(input logic [LEVEL_W-1:0] lv);
        return SMALL_DUTY_TAB[tab_ix(lv)];
    endfunction

    function automatic logic [DUTY_W-1:0] large_duty(input logic [LEVEL_W-1:0] lv);
        return LARGE_DUTY_TAB[tab_ix(lv)];
    endfunction

    function automatic logic hold_hit(input logic [ARG_W-1:0] arg);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(arg) * PROD_W'(HOLD_RECIP);
        return {1'b0, prod[HOLD_SHIFT-1:0]} < HOLD_RECIP;
    endfunction

endpackage

`default_nettype wire

[rtl/core/led_brightness_mode_controller.sv]
// Top level of the LED brightness and mode controller.
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+-------------------------------
//  in      | sink      | i_in_valid/o_in_stall | t_in_word: event_code, event_arg
//  out     | source    | o_out_valid/i_out_stall | t_out_word: six result fields
//  cfg     | sink      | i_cfg_valid/o_cfg_ready | standby_delay, 16 bit
//
// One word per cycle sustained while the result register is not stalled.
// A word is registered in the input register, then one step of event logic
// updates the state and loads the result register.
// Reset (i_rst_n low, synchronous) restores mode off, level 0, memorized
// level 1 and the duty registers to 3/0; standby_delay returns to 62.
// A stalled result register holds; the input register still takes one more
// word behind it, and o_in_stall rises only when both are full.
`default_nettype none

module led_brightness_mode_controller (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // event input
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  var  lbmc_pkg::t_in_word         i_in_data,
    // result output
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output lbmc_pkg::t_out_word             o_out_data,
    // standby_delay register write
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [lbmc_pkg::ARG_W-1:0] i_cfg_data
);

    // input stage
    logic                        r_in_valid, n_in_valid;
    lbmc_pkg::t_in_word          r_in_word;

    // controller state
    lbmc_pkg::t_state            r_state, n_state;
    logic [lbmc_pkg::ARG_W-1:0]  r_standby_delay;

    // result stage
    logic                        r_out_valid, n_out_valid;
    lbmc_pkg::t_out_word         r_out_word, n_out_word;

    logic                        w_in_take;   // word accepted into input reg
    logic                        w_advance;   // input reg word stepped this cycle

    lbmc_step u_step (
        .i_state         (r_state),
        .i_word          (r_in_word),
        .i_standby_delay (r_standby_delay),
        .o_state         (n_state),
        .o_result        (n_out_word)
    );

    // step fires when the result register is free or being emptied
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_take) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_state         <= lbmc_pkg::STATE_RESET;
            r_standby_delay <= lbmc_pkg::STANDBY_DELAY_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_advance) begin
                r_state <= n_state;
            end
            if (i_cfg_valid) begin
                r_standby_delay <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_word <= i_in_data;
        end
        if (w_advance) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_word;

    // brightness level never leaves the table range
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.cur_level <= lbmc_pkg::TOP_LEVEL)
        else $error("level above top");

    // standby only comes with off as the new mode or from a lockout tick
    a_standby_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && n_out_word.standby_request) |->
        (n_out_word.mode_now == lbmc_pkg::MODE_OFF ||
         n_out_word.mode_now == lbmc_pkg::MODE_LOCK))
        else $error("standby outside off or lockout");

    // a stepped word always lands in the result register
    a_step_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (r_out_valid && r_out_word == $past(n_out_word)))
        else $error("stepped word lost");

endmodule

`default_nettype wire

[rtl/core/lbmc_step.sv]
// Single-step event logic: next controller state and result word.
`default_nettype none

module lbmc_step (
    input  var lbmc_pkg::t_state    i_state,
    input  var lbmc_pkg::t_in_word  i_word,
    input  wire logic [lbmc_pkg::ARG_W-1:0] i_standby_delay,
    output lbmc_pkg::t_state        o_state,
    output lbmc_pkg::t_out_word     o_result
);

    lbmc_pkg::t_state               st;
    logic                           handled;
    logic                           sleep;
    logic                           entry;
    logic [lbmc_pkg::LEVEL_W-1:0]   entry_lv;
    logic                           set_lv;
    logic [lbmc_pkg::LEVEL_W-1:0]   new_lv;
    lbmc_pkg::t_event               ev;

    always_comb begin
        st       = i_state;
        handled  = 1'b0;
        sleep    = 1'b0;
        entry    = 1'b0;
        entry_lv = '0;
        set_lv   = 1'b0;
        new_lv   = '0;
        ev       = lbmc_pkg::t_event'(i_word.event_code);

        if (ev == lbmc_pkg::EV_LOW_VOLTAGE) begin
            // handled by no mode; step down or drop to off
            if (i_state.cur_level != '0) begin
                set_lv        = 1'b1;
                new_lv        = i_state.cur_level - 3'd1;
                st.goal_level = i_state.cur_level - 3'd1;
            end else begin
                st.mode = lbmc_pkg::MODE_OFF;
                sleep   = 1'b1;
            end
        end else begin
            unique case (i_state.mode)
                lbmc_pkg::MODE_OFF: begin
                    handled = 1'b1;
                    unique case (ev)
                        lbmc_pkg::EV_PRESS: begin
                            set_lv = 1'b1;
                            new_lv = '0;
                        end
                        lbmc_pkg::EV_HOLD: begin
                            entry    = 1'b1;
                            entry_lv = '0;
                        end
                        lbmc_pkg::EV_RELEASE: begin
                            set_lv = 1'b1;
                            new_lv = i_state.mem_level;
                        end
                        lbmc_pkg::EV_CLICK1: begin
                            entry    = 1'b1;
                            entry_lv = i_state.mem_level;
                        end
                        lbmc_pkg::EV_CLICK2: begin
                            entry    = 1'b1;
                            entry_lv = lbmc_pkg::TOP_LEVEL;
                        end
                        lbmc_pkg::EV_CLICK4: begin
                            st.mode = lbmc_pkg::MODE_LOCK;
                        end
                        default: handled = 1'b0;
                    endcase
                end
                lbmc_pkg::MODE_STEADY: begin
                    handled = 1'b1;
                    unique case (ev)
                        lbmc_pkg::EV_CLICK1: begin
                            st.mode = lbmc_pkg::MODE_OFF;
                            sleep   = 1'b1;
                        end
                        lbmc_pkg::EV_CLICK2: begin
                            set_lv = 1'b1;
                            if (i_state.cur_level < lbmc_pkg::TOP_LEVEL) begin
                                st.mem_level  = i_state.cur_level;
                                st.goal_level = lbmc_pkg::TOP_LEVEL;
                                new_lv        = lbmc_pkg::TOP_LEVEL;
                            end else begin
                                st.goal_level = i_state.mem_level;
                                new_lv        = i_state.mem_level;
                            end
                        end
                        lbmc_pkg::EV_HOLD: begin
                            if (lbmc_pkg::hold_hit(i_word.event_arg)) begin
                                // ramp wraps from top back to zero
                                new_lv = (i_state.cur_level >= lbmc_pkg::TOP_LEVEL) ?
                                         '0 : i_state.cur_level + 3'd1;
                                set_lv        = 1'b1;
                                st.mem_level  = new_lv;
                                st.goal_level = new_lv;
                            end
                        end
                        lbmc_pkg::EV_HOT: begin
                            if (i_state.cur_level > 3'd1) begin
                                set_lv = 1'b1;
                                new_lv = i_state.cur_level - 3'd1;
                            end
                        end
                        lbmc_pkg::EV_COOL: begin
                            if (i_state.cur_level < i_state.goal_level) begin
                                set_lv = 1'b1;
                                new_lv = i_state.cur_level + 3'd1;
                            end
                        end
                        default: handled = 1'b0;
                    endcase
                end
                lbmc_pkg::MODE_LOCK: begin
                    if (ev == lbmc_pkg::EV_TICK) begin
                        handled       = 1'b1;
                        st.duty_small = '0;
                        st.duty_large = '0;
                        sleep         = (i_word.event_arg > i_standby_delay);
                    end else if (ev == lbmc_pkg::EV_CLICK4) begin
                        handled  = 1'b1;
                        entry    = 1'b1;
                        entry_lv = 3'd1;
                    end
                end
                default: handled = 1'b0;
            endcase
        end

        // steady entry rule
        if (entry) begin
            st.mode = lbmc_pkg::MODE_STEADY;
            if (entry_lv != '0 && entry_lv < lbmc_pkg::TOP_LEVEL) begin
                st.mem_level = entry_lv;
            end
            st.goal_level = entry_lv;
            set_lv        = 1'b1;
            new_lv        = entry_lv;
        end

        if (set_lv) begin
            st.cur_level  = new_lv;
            st.duty_small = lbmc_pkg::small_duty(new_lv);
            st.duty_large = lbmc_pkg::large_duty(new_lv);
        end
    end

    assign o_state = st;

    assign o_result = '{
        handled:            handled,
        mode_now:           st.mode,
        level_now:          st.cur_level,
        duty_small_channel: st.duty_small,
        duty_large_channel: st.duty_large,
        standby_request:    sleep
    };

endmodule

`default_nettype wire

[sim/tb_led_brightness_mode_controller.sv]
// Testbench for led_brightness_mode_controller: directed and random event streams, scoreboarded.
`timescale 1ns / 100ps

module tb_led_brightness_mode_controller;
    import lbmc_pkg::*;

    // Brightness range and hold repeat period of the controller being tested
    localparam logic [2:0] LVL_MAX    = 3'd6;
    localparam int         HOLD_TICKS = 24;

    // Duty per level: small emitter and FET channel
    localparam logic [7:0] SMALL_LUT [7] = '{
        8'd3, 8'd18, 8'd110, 8'd255, 8'd255, 8'd255, 8'd0
    };
    localparam logic [7:0] LARGE_LUT [7] = '{
        8'd0, 8'd0, 8'd0, 8'd9, 8'd58, 8'd138, 8'd255
    };

    // Word passes the input and result registers; allow slack for a stalled
    // result register plus the skid word behind it.
    localparam int DRAIN_CYCLES = 8;
    localparam int RUN_LIMIT_NS = 2_000_000;
    localparam int WORDS_PER_PHASE = 120;
    localparam int PAUSE_EVERY  = 40;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_word             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_word            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [ARG_W-1:0]     i_cfg_data;

    led_brightness_mode_controller i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Idle rates in percent of cycles, changed per phase
    int in_idle_pct;
    int out_stall_pct;
    int fail_count;

    // Expected result words, oldest first
    t_out_word led_expect_q[$];

    // ---------------------------------------------------------------------
    // Controller state as the testbench tracks it
    // ---------------------------------------------------------------------
    t_mode       mode_q;
    logic [2:0]  level_q;
    logic [2:0]  memo_level_q;
    logic [2:0]  goal_level_q;
    logic [7:0]  duty_small_q;
    logic [7:0]  duty_large_q;
    logic [15:0] standby_delay_q;

    task automatic reset_led_model();
        mode_q          = MODE_OFF;
        level_q         = 3'd0;
        memo_level_q    = 3'd1;
        goal_level_q    = 3'd0;
        duty_small_q    = 8'd3;
        duty_large_q    = 8'd0;
        standby_delay_q = 16'd62;
    endtask

    // Load both duty registers from the tables for level lv
    function automatic void show_level(input logic [2:0] lv);
        level_q      = lv;
        duty_small_q = SMALL_LUT[lv];
        duty_large_q = LARGE_LUT[lv];
    endfunction

    // Steady entry: extremes are not memorized, goal tracks the entry level
    function automatic void enter_steady_at(input logic [2:0] lv);
        mode_q = MODE_STEADY;
        if (lv > 3'd0 && lv < LVL_MAX)
            memo_level_q = lv;
        goal_level_q = lv;
        show_level(lv);
    endfunction

    // One event through the current mode; returns the result word it gives
    function automatic t_out_word step_led_model(input logic [3:0] code,
                                                 input logic [15:0] arg);
        t_out_word res;
        logic      took;
        logic      sleep;
        took  = 1'b0;
        sleep = 1'b0;
        if (code == EV_LOW_VOLTAGE) begin
            // Not handled by any mode: step down, or drop to off at level 0
            if (level_q != 3'd0) begin
                show_level(level_q - 3'd1);
                goal_level_q = level_q;
            end else begin
                mode_q = MODE_OFF;
                sleep  = 1'b1;
            end
        end else begin
            case (mode_q)
                MODE_OFF: begin
                    took = 1'b1;
                    case (code)
                        EV_PRESS:   show_level(3'd0);
                        EV_HOLD:    enter_steady_at(3'd0);
                        EV_RELEASE: show_level(memo_level_q);
                        EV_CLICK1:  enter_steady_at(memo_level_q);
                        EV_CLICK2:  enter_steady_at(LVL_MAX);
                        EV_CLICK4:  mode_q = MODE_LOCK;
                        default:    took = 1'b0;
                    endcase
                end
                MODE_STEADY: begin
                    took = 1'b1;
                    case (code)
                        EV_CLICK1: begin
                            mode_q = MODE_OFF;
                            sleep  = 1'b1;
                        end
                        EV_CLICK2: begin
                            // Toggle between top and the memorized level
                            if (level_q < LVL_MAX) begin
                                memo_level_q = level_q;
                                goal_level_q = LVL_MAX;
                                show_level(LVL_MAX);
                            end else begin
                                goal_level_q = memo_level_q;
                                show_level(memo_level_q);
                            end
                        end
                        EV_HOLD: begin
                            // Ramp one level per hold period, wrapping past top
                            if ((int'(arg) % HOLD_TICKS) == 0) begin
                                memo_level_q = 3'((int'(level_q) + 1) % (int'(LVL_MAX) + 1));
                                goal_level_q = memo_level_q;
                                show_level(memo_level_q);
                            end
                        end
                        EV_HOT: begin
                            if (level_q > 3'd1)
                                show_level(level_q - 3'd1);
                        end
                        EV_COOL: begin
                            if (level_q < goal_level_q)
                                show_level(level_q + 3'd1);
                        end
                        default: took = 1'b0;
                    endcase
                end
                MODE_LOCK: begin
                    if (code == EV_TICK) begin
                        took         = 1'b1;
                        duty_small_q = 8'd0;
                        duty_large_q = 8'd0;
                        if (arg > standby_delay_q)
                            sleep = 1'b1;
                    end else if (code == EV_CLICK4) begin
                        took = 1'b1;
                        enter_steady_at(3'd1);
                    end
                end
                default: took = 1'b0;
            endcase
        end
        res.handled            = took;
        res.mode_now           = mode_q;
        res.level_now          = level_q;
        res.duty_small_channel = duty_small_q;
        res.duty_large_channel = duty_large_q;
        res.standby_request    = sleep;
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Handshake helpers
    // ---------------------------------------------------------------------

    // Present one event word; the model steps at the edge that takes it.
    // Valid stays high afterwards so back-to-back words need no gap.
    task automatic send_event(input logic [3:0] code, input logic [15:0] arg);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= '{event_code: code, event_arg: arg};
        do @(posedge i_clk); while (o_in_stall);
        led_expect_q.push_back(step_led_model(code, arg));
    endtask

    // Drop valid, then wait until every expected word is back and the
    // pipeline has settled
    task automatic park_and_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (led_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_standby_delay(input logic [15:0] value);
        park_and_drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        standby_delay_q = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver stalls at random, one decision per cycle
    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);

    // ---------------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    t_out_word want_w;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (led_expect_q.size() == 0) begin
                $error("result word with no event pending");
                fail_count++;
            end else begin
                want_w = led_expect_q.pop_front();
                check_field("handled", want_w.handled, o_out_data.handled);
                check_field("mode_now", want_w.mode_now, o_out_data.mode_now);
                check_field("level_now", want_w.level_now, o_out_data.level_now);
                check_field("duty_small_channel", want_w.duty_small_channel,
                            o_out_data.duty_small_channel);
                check_field("duty_large_channel", want_w.duty_large_channel,
                            o_out_data.duty_large_channel);
                check_field("standby_request", want_w.standby_request,
                            o_out_data.standby_request);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Off mode from reset: previews, unlisted codes, jump to top
    task automatic test_off_mode();
        send_event(EV_PRESS, 16'h0000);
        send_event(EV_RELEASE, 16'h0000);     // shows memorized level 1
        send_event(4'hF, 16'hFFFF);           // code beyond the event list
        send_event(EV_HOT, 16'h1234);         // listed code, not an off event
        send_event(EV_CLICK2, 16'h0000);      // steady at top
    endtask

    // Steady: toggle, hold ramp with wrap, thermal step down and recovery
    task automatic test_steady_mode();
        send_event(EV_CLICK2, 16'h0000);      // top -> memorized
        send_event(EV_HOLD, 16'hFFFF);        // not a period multiple
        send_event(EV_HOLD, 16'h0000);        // period multiple, level up
        send_event(EV_CLICK2, 16'h5A5A);      // up to top, memorizes current
        send_event(EV_HOT, 16'h0000);
        send_event(EV_COOL, 16'h0000);
        send_event(EV_HOLD, 16'(HOLD_TICKS)); // top wraps to 0
        send_event(EV_CLICK1, 16'h0000);      // off, standby raised
    endtask

    // Lockout: ignored press, tick clears duties, standby past the delay
    task automatic test_lockout_mode();
        send_event(EV_CLICK4, 16'h0000);
        send_event(EV_PRESS, 16'h0000);
        send_event(EV_TICK, 16'h0000);
        send_event(EV_TICK, 16'hFFFF);
        send_event(EV_CLICK4, 16'h0000);      // back to steady at 1
    endtask

    // Low voltage steps down, then at level 0 forces off
    task automatic test_low_voltage();
        send_event(EV_LOW_VOLTAGE, 16'h0000);
        send_event(EV_LOW_VOLTAGE, 16'hFFFF);
    endtask

    // Delay register at both extremes, probed right at the threshold
    task automatic test_standby_delay();
        write_standby_delay(16'h0000);
        send_event(EV_CLICK4, 16'h0000);
        send_event(EV_TICK, 16'h0000);        // equal: no standby
        send_event(EV_TICK, 16'h0001);
        write_standby_delay(16'hFFFF);
        send_event(EV_TICK, 16'hFFFF);        // never above the max delay
    endtask

    // Weighted event mix; hold and tick arguments bunch where they matter
    task automatic pick_event(output logic [3:0] code, output logic [15:0] arg);
        int pick;
        int near;
        arg = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 99) < 6) begin
            code = 4'($urandom_range(int'(EV_LOW_VOLTAGE) + 1, 15));
        end else begin
            pick = $urandom_range(0, 19);
            if (pick < 2)       code = EV_PRESS;
            else if (pick < 5)  code = EV_HOLD;
            else if (pick < 6)  code = EV_RELEASE;
            else if (pick < 8)  code = EV_CLICK1;
            else if (pick < 10) code = EV_CLICK2;
            else if (pick < 13) code = EV_CLICK4;
            else if (pick < 15) code = EV_HOT;
            else if (pick < 17) code = EV_COOL;
            else if (pick < 19) code = EV_TICK;
            else                code = EV_LOW_VOLTAGE;
            if (code == EV_HOLD && $urandom_range(0, 99) < 60)
                arg = 16'($urandom_range(0, 65535 / HOLD_TICKS) * HOLD_TICKS);
            if (code == EV_TICK && $urandom_range(0, 1) == 1) begin
                near = int'(standby_delay_q) + $urandom_range(0, 4) - 2;
                arg  = (near < 0) ? 16'h0000 : (near > 65535) ? 16'hFFFF : 16'(near);
            end
        end
    endtask

    task automatic test_random_events(input int words, input logic [15:0] delay);
        logic [3:0]  code;
        logic [15:0] arg;
        int          counted;
        counted = 0;
        write_standby_delay(delay);
        while (counted < words) begin
            pick_event(code, arg);
            send_event(code, arg);
            if (code <= EV_LOW_VOLTAGE)
                counted++;
            // Sender holds off now and then until the block is empty
            if (counted % PAUSE_EVERY == 0 && code <= EV_LOW_VOLTAGE)
                park_and_drain();
        end
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_stall   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        fail_count    = 0;
        in_idle_pct   = 30;
        out_stall_pct = 66;
        reset_led_model();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_off_mode();
        test_steady_mode();
        test_lockout_mode();
        test_low_voltage();
        test_standby_delay();

        // Busy sender, slow receiver; short delay so ticks cross it often
        test_random_events(WORDS_PER_PHASE, 16'($urandom_range(0, 100)));
        // Slow sender, busy receiver; any delay
        in_idle_pct   = 66;
        out_stall_pct = 30;
        test_random_events(WORDS_PER_PHASE, 16'($urandom_range(0, 65535)));
        // Full rate both ways, delay back at its reset value
        in_idle_pct   = 0;
        out_stall_pct = 0;
        test_random_events(WORDS_PER_PHASE, 16'd62);

        park_and_drain();
        if (fail_count == 0)
            $display("tb_led_brightness_mode_controller passed");
        else
            $display("tb_led_brightness_mode_controller failed");
        $finish;
    end

    // Hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("tb_led_brightness_mode_controller failed");
        $finish;
    end

endmodule

[files.f]
rtl/core/lbmc_pkg.sv
rtl/core/lbmc_step.sv
rtl/core/led_brightness_mode_controller.sv
sim/tb_led_brightness_mode_controller.sv
